>>> rtl/jsonc_trailing_comma_finder_unit_defines.svh
`ifndef JSONC_TRAILING_COMMA_FINDER_UNIT_DEFINES_SVH
`define JSONC_TRAILING_COMMA_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define JTC_ASSERT_IMPLIES(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("jtc check failed: same-cycle implication");

// Always-true invariant, checked while out of reset
`define JTC_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("jtc check failed: invariant");

`endif

>>> rtl/jtc_pkg.sv
`default_nettype none

package jtc_pkg;

	localparam int unsigned POSITION_BITS = 24;

	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam pos_t POS_MAX = '1;

	// result data: comma_position, bom_removed, trailing_count, padded to bytes
	localparam int unsigned OUT_DATA_BITS = ((2 * POSITION_BITS + 1 + 7) / 8) * 8;

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_STRING     = 3'd2,
		MODE_STRING_ESC = 3'd3,
		MODE_LINE       = 3'd4,
		MODE_BLOCK      = 3'd5,
		MODE_BLOCK_STAR = 3'd6
	} lex_mode_t;

	typedef enum logic [1:0] {
		MARK_EF   = 2'd0,
		MARK_BB   = 2'd1,
		MARK_BF   = 2'd2,
		MARK_DONE = 2'd3
	} mark_stage_t;

	localparam logic KIND_COMMA   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] BOM_0       = 8'hEF;
	localparam logic [7:0] BOM_1       = 8'hBB;
	localparam logic [7:0] BOM_2       = 8'hBF;

	typedef struct packed {
		logic kind;
		pos_t pos;
		logic bom;
		pos_t count;
		logic last;
	} result_t;

	// what the lexer reports for the byte it consumes this cycle
	typedef struct packed {
		logic hit;
		logic fin;
		pos_t hit_pos;
		logic bom;
		pos_t count;
	} lex_res_t;

endpackage

`default_nettype wire

>>> rtl/jtc_lexer.sv
`default_nettype none

module jtc_lexer import jtc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     advance,
	input  wire logic [7:0] text_byte,
	input  wire logic     final_byte,
	output lex_res_t      res
);

	lex_mode_t   mode_q, mode_d;
	logic        waiting_q, waiting_d;
	pos_t        wait_pos_q, wait_pos_d;
	pos_t        index_q, index_d;
	mark_stage_t mark_q, mark_d;
	logic        found_q, found_d;
	pos_t        count_q, count_d;

	logic hit;
	logic run_normal;
	logic handled;
	logic blank;
	logic mark_now;

	assign blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
		(text_byte == CH_CR) || (text_byte == CH_LF);

	always_comb begin
		mode_d     = mode_q;
		waiting_d  = waiting_q;
		wait_pos_d = wait_pos_q;
		hit        = 1'b0;
		run_normal = 1'b0;
		handled    = 1'b0;
		unique case (mode_q)
			MODE_SLASH: begin
				if (text_byte == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (text_byte == CH_STAR) begin
					mode_d = MODE_BLOCK;
				end else begin
					// lone slash was significant: drop the comma, relex this byte
					waiting_d  = 1'b0;
					mode_d     = MODE_NORMAL;
					run_normal = 1'b1;
				end
			end
			MODE_STRING: begin
				if (text_byte == CH_BSLASH) begin
					mode_d = MODE_STRING_ESC;
				end else if (text_byte == CH_QUOTE) begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_STRING_ESC: mode_d = MODE_STRING;
			MODE_LINE: begin
				if (text_byte == CH_LF) begin
					mode_d     = MODE_NORMAL;
					run_normal = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (text_byte == CH_STAR) begin
					mode_d = MODE_BLOCK_STAR;
				end
			end
			MODE_BLOCK_STAR: begin
				if (text_byte == CH_SLASH) begin
					mode_d = MODE_NORMAL;
				end else if (text_byte != CH_STAR) begin
					mode_d = MODE_BLOCK;
				end
			end
			default: begin
				mode_d     = MODE_NORMAL;
				run_normal = 1'b1;
			end
		endcase

		if (run_normal) begin
			if (waiting_d) begin
				if (blank) begin
					handled = 1'b1;
				end else if (text_byte == CH_SLASH) begin
					mode_d  = MODE_SLASH;
					handled = 1'b1;
				end else begin
					waiting_d = 1'b0;
					if ((text_byte == CH_RBRACE) || (text_byte == CH_RBRACKET)) begin
						hit     = 1'b1;
						handled = 1'b1;
					end
				end
			end
			if (!handled) begin
				if (text_byte == CH_QUOTE) begin
					mode_d = MODE_STRING;
				end else if (text_byte == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else if (text_byte == CH_COMMA) begin
					waiting_d  = 1'b1;
					wait_pos_d = index_q;
				end
			end
		end
	end

	always_comb begin
		mark_d   = mark_q;
		found_d  = found_q;
		mark_now = 1'b0;
		unique case (mark_q)
			MARK_EF: mark_d = (text_byte == BOM_0) ? MARK_BB : MARK_DONE;
			MARK_BB: mark_d = (text_byte == BOM_1) ? MARK_BF : MARK_DONE;
			MARK_BF: begin
				mark_d = MARK_DONE;
				if (text_byte == BOM_2) begin
					found_d  = 1'b1;
					mark_now = 1'b1;
				end
			end
			MARK_DONE: mark_d = MARK_DONE;
			default:   mark_d = MARK_DONE;
		endcase
	end

	// the mark is dropped from the numbering, so text restarts at zero after it
	assign index_d = mark_now ? '0 : ((index_q != POS_MAX) ? index_q + 1'b1 : index_q);
	assign count_d = (hit && (count_q != POS_MAX)) ? count_q + 1'b1 : count_q;

	assign res = '{hit: hit, fin: final_byte, hit_pos: wait_pos_q, bom: found_d,
		count: count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			waiting_q  <= 1'b0;
			wait_pos_q <= '0;
			index_q    <= '0;
			mark_q     <= MARK_EF;
			found_q    <= 1'b0;
			count_q    <= '0;
		end else if (advance) begin
			if (final_byte) begin
				mode_q     <= MODE_NORMAL;
				waiting_q  <= 1'b0;
				wait_pos_q <= '0;
				index_q    <= '0;
				mark_q     <= MARK_EF;
				found_q    <= 1'b0;
				count_q    <= '0;
			end else begin
				mode_q     <= mode_d;
				waiting_q  <= waiting_d;
				wait_pos_q <= wait_pos_d;
				index_q    <= index_d;
				mark_q     <= mark_d;
				found_q    <= found_d;
				count_q    <= count_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/jsonc_trailing_comma_finder_unit.sv
`default_nettype none
`include "jsonc_trailing_comma_finder_unit_defines.svh"

// JSONC trailing-comma finder. Takes one byte of text per request on the s_ side
// (s_tlast marks the last byte) and reports, on the m_ side, the position of each
// comma whose next significant byte is a closing brace or bracket, numbered after
// a leading EF BB BF mark is dropped, and an end summary after the last byte.
// A byte is registered, then lexed, and its results land in a four-entry output
// queue; one byte is taken every clock while the queue has room for two results,
// so the sustained rate is one byte per cycle, limited only by the consumer
// taking one result per cycle. The bytes themselves are not rewritten.
module jsonc_trailing_comma_finder_unit import jtc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [7:0]               s_tdata,  // [7:0] text_byte
	input  wire logic                     s_tlast,  // final_byte
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0]      m_tdata,  // comma_position, bom_removed, trailing_count
	output logic                          m_tuser,  // kind
	output logic                          m_tlast   // last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	logic     advance;
	lex_res_t res;

	result_t    queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] fill_q;

	result_t    res_comma;
	result_t    res_summary;
	result_t    head;
	logic       pop;
	logic [1:0] push_n;

	// room for the worst case of two results before a byte is lexed
	assign advance  = valid_s1 && (fill_q <= 3'd2);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	jtc_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.text_byte  (byte_s1),
		.final_byte (final_s1),
		.res        (res)
	);

	assign res_comma = '{kind: KIND_COMMA, pos: res.hit_pos, bom: res.bom,
		count: res.count, last: !res.fin};
	assign res_summary = '{kind: KIND_SUMMARY, pos: '0, bom: res.bom,
		count: res.count, last: 1'b1};

	assign push_n = advance ? ({1'b0, res.hit} + {1'b0, res.fin}) : 2'd0;
	assign pop    = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (res.hit) begin
				queue_q[wr_ptr_q] <= res_comma;
				if (res.fin) begin
					queue_q[wr_ptr_q + 2'd1] <= res_summary;
				end
			end else if (res.fin) begin
				queue_q[wr_ptr_q] <= res_summary;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			fill_q   <= fill_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = (fill_q != 3'd0);
	assign m_tdata  = OUT_DATA_BITS'({head.count, head.bom, head.pos});
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

	`JTC_ASSERT_ALWAYS(a_fill_bound, fill_q <= 3'd4)
	`JTC_ASSERT_IMPLIES(a_room_on_advance, advance, fill_q <= 3'd2)
	`JTC_ASSERT_IMPLIES(a_summary_last, m_tvalid && (m_tuser == KIND_SUMMARY), m_tlast)
	`JTC_ASSERT_IMPLIES(a_comma_counted, m_tvalid && (m_tuser == KIND_COMMA), head.count != '0)

endmodule

`default_nettype wire
